// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define DLRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that a condition never occurs.
`define DLRC_ASSERT_NEVER(lbl, cond, msg) \
	`DLRC_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/dlrc_pkg.sv =====
`timescale 1ns / 1ps

package dlrc_pkg;

	// Action codes of an input item.
	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_FIND = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	// Width of slot counters; holds any table depth up to 8191.
	localparam int CNT_W = 13;

	typedef struct packed {
		logic [1:0]  action;
		logic [6:0]  entry_index;
		logic [7:0]  entry_type;
		logic [15:0] entry_id;
		logic [7:0]  entry_flags;
		logic [15:0] entry_next_id;
		logic [31:0] entry_pos;
		logic [31:0] entry_length;
		logic [15:0] entry_crc;
		logic [31:0] read_size;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  hit_type;
		logic [7:0]  hit_flags;
		logic [15:0] hit_id;
		logic [15:0] hit_next_id;
		logic [31:0] hit_pos;
		logic [31:0] hit_length;
		logic [15:0] hit_crc;
		logic [31:0] granted_size;
		logic [31:0] read_address;
	} out_item_t;

	// One directory slot as stored in the table memory (128 bits).
	typedef struct packed {
		logic [7:0]  etype;
		logic [7:0]  flags;
		logic [15:0] id;
		logic [15:0] next_id;
		logic [31:0] pos;
		logic [31:0] length;
		logic [15:0] crc;
	} dir_entry_t;

	// Request from the top level to start a table scan.
	typedef struct packed {
		logic        start;
		logic [7:0]  key_type;
		logic [15:0] key_id;
	} scan_req_t;

	// Completion report of a table scan.
	typedef struct packed {
		logic       done;
		logic       hit;
		dir_entry_t entry;
	} scan_res_t;

	typedef enum logic {
		ST_IDLE,
		ST_FIND
	} top_state_t;

	typedef enum logic {
		SC_IDLE,
		SC_RUN
	} scan_state_t;

endpackage

// ===== rtl/directory_lookup_read_cursor_core.sv =====
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     in_valid / in_ready   in_item  (dlrc_pkg::in_item_t)
// output    out_valid / out_ready out_item (dlrc_pkg::out_item_t)
// config    cfg_wr_en             cfg_wr_data (entry_count, 8 bits)
//
// Load, read and unused actions give their result in the cycle after acceptance.
// A find looks at no more than min(entry_count, DIR_DEPTH) slots; the table scan reads one
// slot per cycle through the registered read port of the table memory.
// A find stops at the first hit; with entry_count zero it misses without reading a slot.
// One item is worked on at a time; a new item is taken as the previous result leaves.
// Reset clears the cursor, entry_count and control state; the table is not cleared.

`include "assert_macros.svh"

module directory_lookup_read_cursor_core #(
	parameter int DIR_DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dlrc_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output dlrc_pkg::out_item_t out_item,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data
);

	localparam int AW = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;

	dlrc_pkg::top_state_t state_q, state_d;
	dlrc_pkg::scan_req_t  scan_req;
	dlrc_pkg::scan_res_t  scan_res;
	dlrc_pkg::dir_entry_t wr_entry;
	dlrc_pkg::dir_entry_t rd_entry;
	dlrc_pkg::out_item_t  item_d;
	dlrc_pkg::out_item_t  out_item_q;
	logic                 out_valid_q;
	logic [7:0]           count_q;
	logic [31:0]          pos_q;
	logic [31:0]          rem_q;
	logic [31:0]          grant;
	logic                 accept;
	logic                 is_find;
	logic                 is_read;
	logic                 wr_en;
	logic [dlrc_pkg::CNT_W-1:0] idx_ext;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 in_find;
	logic                 read_acc;

	assign accept  = in_valid && in_ready;
	assign is_find = (in_item.action == dlrc_pkg::ACT_FIND);
	assign is_read = (in_item.action == dlrc_pkg::ACT_READ);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dlrc_pkg::ST_IDLE: begin
				if (accept && is_find) begin
					state_d = dlrc_pkg::ST_FIND;
				end
			end
			dlrc_pkg::ST_FIND: begin
				if (scan_res.done) begin
					state_d = dlrc_pkg::ST_IDLE;
				end
			end
			default: state_d = dlrc_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready = 1'b0;
		case (state_q)
			dlrc_pkg::ST_IDLE: in_ready = !out_valid_q || out_ready;
			default:           in_ready = 1'b0;
		endcase
	end

	assign scan_req.start    = accept && is_find;
	assign scan_req.key_type = in_item.entry_type;
	assign scan_req.key_id   = in_item.entry_id;

	// Load writes a slot when its index lies inside the table.
	assign idx_ext = dlrc_pkg::CNT_W'(in_item.entry_index);
	assign wr_en   = accept && (in_item.action == dlrc_pkg::ACT_LOAD) &&
		(idx_ext < dlrc_pkg::CNT_W'(DIR_DEPTH));

	assign wr_entry.etype   = in_item.entry_type;
	assign wr_entry.flags   = in_item.entry_flags;
	assign wr_entry.id      = in_item.entry_id;
	assign wr_entry.next_id = in_item.entry_next_id;
	assign wr_entry.pos     = in_item.entry_pos;
	assign wr_entry.length  = in_item.entry_length;
	assign wr_entry.crc     = in_item.entry_crc;

	dlrc_ram #(
		.WIDTH ($bits(dlrc_pkg::dir_entry_t)),
		.DEPTH (DIR_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_ext[AW-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	dlrc_scan #(
		.DIR_DEPTH (DIR_DEPTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (scan_req),
		.entry_count (count_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_entry),
		.res         (scan_res)
	);

	// Grant of a read item.
	assign grant = (in_item.read_size > rem_q) ? rem_q : in_item.read_size;

	// Result of the item that completes this cycle.
	always_comb begin
		item_d = '0;
		if (scan_res.done) begin
			if (scan_res.hit) begin
				item_d.found       = 1'b1;
				item_d.hit_type    = scan_res.entry.etype;
				item_d.hit_flags   = scan_res.entry.flags;
				item_d.hit_id      = scan_res.entry.id;
				item_d.hit_next_id = scan_res.entry.next_id;
				item_d.hit_pos     = scan_res.entry.pos;
				item_d.hit_length  = scan_res.entry.length;
				item_d.hit_crc     = scan_res.entry.crc;
			end
		end else if (is_read) begin
			item_d.granted_size = grant;
			item_d.read_address = pos_q;
		end
	end

	// Configuration, cursor and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dlrc_pkg::ST_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				count_q <= cfg_wr_data;
			end
			if (scan_res.done) begin
				pos_q <= scan_res.hit ? scan_res.entry.pos : 32'd0;
				rem_q <= scan_res.hit ? scan_res.entry.length : 32'd0;
			end else if (accept && is_read) begin
				pos_q <= pos_q + grant;
				rem_q <= rem_q - grant;
			end
			if (scan_res.done || (accept && !is_find)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (scan_res.done || (accept && !is_find)) begin
			out_item_q <= item_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign in_find  = (state_q == dlrc_pkg::ST_FIND);
	assign read_acc = accept && is_read;

	// The output register stays empty while a scan runs.
	`DLRC_ASSERT(a_no_result_in_find, in_find |-> !out_valid_q, "result during find")
	// A scan completes only while the sequencer waits for it.
	`DLRC_ASSERT(a_done_in_find, scan_res.done |-> in_find, "stray scan done")
	// A read never grants more than the cursor holds.
	`DLRC_ASSERT(a_grant_bound, read_acc |=> out_item_q.granted_size <= $past(rem_q), "big grant")
	// The table is never written while it is being scanned.
	`DLRC_ASSERT_NEVER(a_no_load_in_scan, wr_en && in_find, "load during scan")

endmodule

// ===== rtl/dlrc_ram.sv =====
`timescale 1ns / 1ps

module dlrc_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/dlrc_scan.sv =====
`timescale 1ns / 1ps

module dlrc_scan #(
	parameter int DIR_DEPTH = 128,
	localparam int AW = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dlrc_pkg::scan_req_t req,
	input  logic [7:0]          entry_count,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	input  dlrc_pkg::dir_entry_t rd_data,
	output dlrc_pkg::scan_res_t res
);

	dlrc_pkg::scan_state_t state_q, state_d;
	logic [dlrc_pkg::CNT_W-1:0] ptr_q;
	logic [dlrc_pkg::CNT_W-1:0] limit_q;
	logic [dlrc_pkg::CNT_W-1:0] cnt_ext;
	logic [7:0]  key_type_q;
	logic [15:0] key_id_q;
	logic        pend_q;
	logic        more;
	logic        match;
	logic        done;

	// Count widened to the counter width; it is saturated to the table depth when a scan starts.
	assign cnt_ext = dlrc_pkg::CNT_W'(entry_count);

	// A slot read last cycle is compared against the keys now.
	assign more  = (ptr_q < limit_q);
	assign match = pend_q && (rd_data.etype == key_type_q) && (rd_data.id == key_id_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dlrc_pkg::SC_IDLE: begin
				if (req.start) begin
					state_d = dlrc_pkg::SC_RUN;
				end
			end
			dlrc_pkg::SC_RUN: begin
				if (done) begin
					state_d = dlrc_pkg::SC_IDLE;
				end
			end
			default: state_d = dlrc_pkg::SC_IDLE;
		endcase
	end

	// Outputs: issue the next slot read unless a hit ends the scan.
	always_comb begin
		rd_en = 1'b0;
		done  = 1'b0;
		case (state_q)
			dlrc_pkg::SC_RUN: begin
				rd_en = more && !match;
				done  = match || (!more && !pend_q);
			end
			default: begin
				rd_en = 1'b0;
				done  = 1'b0;
			end
		endcase
	end

	assign rd_addr   = ptr_q[AW-1:0];
	assign res.done  = done;
	assign res.hit   = match;
	assign res.entry = rd_data;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlrc_pkg::SC_IDLE;
			ptr_q   <= '0;
			limit_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dlrc_pkg::SC_IDLE) begin
				pend_q <= 1'b0;
				if (req.start) begin
					ptr_q   <= '0;
					limit_q <= (cnt_ext > dlrc_pkg::CNT_W'(DIR_DEPTH)) ?
						dlrc_pkg::CNT_W'(DIR_DEPTH) : cnt_ext;
				end
			end else begin
				pend_q <= rd_en;
				if (rd_en) begin
					ptr_q <= ptr_q + dlrc_pkg::CNT_W'(1);
				end
			end
		end
	end

	// Search keys.
	always_ff @(posedge clk) begin
		if (req.start && (state_q == dlrc_pkg::SC_IDLE)) begin
			key_type_q <= req.key_type;
			key_id_q   <= req.key_id;
		end
	end

endmodule

// ===== tb/sv/tb_directory_lookup_read_cursor_core.sv =====
`timescale 1ns / 1ps

module tb_directory_lookup_read_cursor_core;

	import dlrc_pkg::*;

	localparam int DIR_DEPTH = 128;
	localparam int PHASE_ITEMS = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 140;

	// The package names no code for the unused action.
	localparam logic [1:0] ACT_NOP = 2'd3;

	// One directory slot as the checker keeps it.
	typedef struct packed {
		logic [7:0]  kind;
		logic [7:0]  flags;
		logic [15:0] id;
		logic [15:0] next_id;
		logic [31:0] pos;
		logic [31:0] length;
		logic [15:0] crc;
	} slot_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	logic      cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = '0;

	// Mirror of the directory and the read cursor.
	slot_t       dir_slots [DIR_DEPTH];
	bit          slot_written [DIR_DEPTH];
	int          loaded_prefix = 0;
	logic [31:0] cur_pos = '0;
	logic [31:0] cur_left = '0;
	logic [7:0]  scan_count = '0;

	out_item_t awaited_replies [$];
	int        errors = 0;
	int        items_sent = 0;
	int        quiet_cycles = 0;
	bit        idle_on = 1'b1;

	directory_lookup_read_cursor_core #(
		.DIR_DEPTH(DIR_DEPTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Works out the answer to one accepted item and updates the mirrored state.
	function automatic out_item_t lookup_and_advance(in_item_t it);
		out_item_t   r;
		int unsigned limit;
		int unsigned i;
		logic [31:0] grant;
		r = '0;
		case (it.action)
		ACT_LOAD: begin
			dir_slots[it.entry_index] = '{it.entry_type, it.entry_flags, it.entry_id,
				it.entry_next_id, it.entry_pos, it.entry_length, it.entry_crc};
			slot_written[it.entry_index] = 1'b1;
			while (loaded_prefix < DIR_DEPTH && slot_written[loaded_prefix])
				loaded_prefix++;
		end
		ACT_FIND: begin
			limit = (scan_count > DIR_DEPTH) ? DIR_DEPTH : scan_count;
			cur_pos = '0;
			cur_left = '0;
			for (i = 0; i < limit; i++) begin
				if (dir_slots[i].kind == it.entry_type && dir_slots[i].id == it.entry_id) begin
					r.found = 1'b1;
					r.hit_type = dir_slots[i].kind;
					r.hit_flags = dir_slots[i].flags;
					r.hit_id = dir_slots[i].id;
					r.hit_next_id = dir_slots[i].next_id;
					r.hit_pos = dir_slots[i].pos;
					r.hit_length = dir_slots[i].length;
					r.hit_crc = dir_slots[i].crc;
					cur_pos = dir_slots[i].pos;
					cur_left = dir_slots[i].length;
					break;
				end
			end
		end
		ACT_READ: begin
			grant = (it.read_size > cur_left) ? cur_left : it.read_size;
			r.granted_size = grant;
			r.read_address = cur_pos;
			cur_pos = cur_pos + grant;
			cur_left = cur_left - grant;
		end
		default: ;
		endcase
		return r;
	endfunction

	// An item with every field random; callers override what matters.
	function automatic in_item_t scramble();
		in_item_t it;
		it.action = 2'($urandom);
		it.entry_index = 7'($urandom);
		it.entry_type = 8'($urandom);
		it.entry_id = 16'($urandom);
		it.entry_flags = 8'($urandom);
		it.entry_next_id = 16'($urandom);
		it.entry_pos = $urandom;
		it.entry_length = $urandom;
		it.entry_crc = 16'($urandom);
		it.read_size = $urandom;
		return it;
	endfunction

	// A load with keys from a narrow set half the time, so that duplicates occur.
	function automatic in_item_t random_load(logic [6:0] idx);
		in_item_t it;
		it = scramble();
		it.action = ACT_LOAD;
		it.entry_index = idx;
		if ($urandom_range(0, 1) == 1) begin
			it.entry_type = 8'($urandom_range(0, 3));
			it.entry_id = 16'($urandom_range(0, 7));
		end
		if ($urandom_range(0, 4) == 0)
			it.entry_pos = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
		0: it.entry_length = '0;
		1, 2, 3, 4: it.entry_length = 32'($urandom_range(0, 300));
		default: ;
		endcase
		return it;
	endfunction

	function automatic logic [31:0] pick_read_size();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return cur_left;
		2: return 32'hFFFF_FFFF;
		3, 4: return $urandom;
		default: return 32'($urandom_range(0, 96));
		endcase
	endfunction

	// Presents one item, with random gaps before it while idle_on is set, and records its answer on acceptance.
	task automatic push_item(in_item_t it);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (!in_ready);
		awaited_replies.push_back(lookup_and_advance(it));
		items_sent++;
	endtask

	// Stops sending and waits until every answer has come back.
	task automatic drain_replies();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_entry_count(logic [7:0] value);
		drain_replies();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		scan_count = value;
	endtask

	task automatic send_load(logic [6:0] idx, logic [7:0] kind, logic [15:0] id,
			logic [7:0] flags, logic [15:0] next_id, logic [31:0] pos,
			logic [31:0] length, logic [15:0] crc);
		in_item_t it;
		it = scramble();
		it.action = ACT_LOAD;
		it.entry_index = idx;
		it.entry_type = kind;
		it.entry_id = id;
		it.entry_flags = flags;
		it.entry_next_id = next_id;
		it.entry_pos = pos;
		it.entry_length = length;
		it.entry_crc = crc;
		push_item(it);
	endtask

	task automatic send_find(logic [7:0] kind, logic [15:0] id);
		in_item_t it;
		it = scramble();
		it.action = ACT_FIND;
		it.entry_type = kind;
		it.entry_id = id;
		push_item(it);
	endtask

	task automatic send_read(logic [31:0] size);
		in_item_t it;
		it = scramble();
		it.action = ACT_READ;
		it.read_size = size;
		push_item(it);
	endtask

	// With nothing searched, finds miss and reads grant nothing.
	task automatic test_reset_state();
		in_item_t it;
		send_find(8'hFF, 16'hFFFF);
		send_read(32'hFFFF_FFFF);
		it = '1;
		it.action = ACT_NOP;
		push_item(it);
	endtask

	// Extreme entries, first match among duplicate keys, cursor wrap and exhaustion.
	task automatic test_directed_lookups();
		send_load(7'd0, 8'h00, 16'h0000, 8'h00, 16'h0000, 32'h0, 32'h0, 16'h0000);
		send_load(7'd1, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF);
		send_load(7'd2, 8'h5A, 16'h1234, 8'hA5, 16'h0042, 32'hFFFF_FFF0, 32'h40, 16'hBEEF);
		send_load(7'd3, 8'h5A, 16'h1234, 8'h3C, 16'h0099, 32'h0000_1000, 32'h10, 16'h1357);
		send_load(7'd127, 8'hC3, 16'h8001, 8'h81, 16'h7FFE, 32'h8000_0001, 32'h7,
			16'h8421);
		write_entry_count(8'd4);
		send_find(8'h00, 16'h0000);
		// A zero-length entry grants nothing but still reports its position.
		send_read(32'd1);
		send_find(8'hFF, 16'hFFFF);
		send_read(32'd0);
		send_read(32'd1);
		send_read(32'hFFFF_FFFF);
		send_read(32'd5);
		// The first of two slots with the same key wins.
		send_find(8'h5A, 16'h1234);
		send_read(32'h20);
		send_read(32'h30);
		// A miss clears the cursor.
		send_find(8'h5A, 16'h1235);
		send_read(32'd7);
		// Slot 2 lies outside a two-slot search.
		write_entry_count(8'd2);
		send_find(8'h5A, 16'h1234);
		send_read(32'd3);
	endtask

	task automatic test_fill_directory();
		int i;
		for (i = 0; i < DIR_DEPTH; i++)
			push_item(random_load(7'(i)));
	endtask

	// A find, mostly of a stored key, followed by reads that walk its data.
	task automatic run_session();
		int unsigned limit;
		int unsigned pick;
		in_item_t    it;
		limit = (scan_count > DIR_DEPTH) ? DIR_DEPTH : scan_count;
		it = scramble();
		it.action = ACT_FIND;
		if (limit > 0 && $urandom_range(0, 9) != 0) begin
			pick = $urandom_range(0, limit - 1);
			it.entry_type = dir_slots[pick].kind;
			it.entry_id = dir_slots[pick].id;
		end else if ($urandom_range(0, 1) == 1) begin
			it.entry_type = 8'($urandom_range(0, 3));
			it.entry_id = 16'($urandom_range(0, 7));
		end
		push_item(it);
		repeat ($urandom_range(1, 6))
			send_read(pick_read_size());
	endtask

	task automatic send_noise();
		in_item_t it;
		it = scramble();
		case ($urandom_range(0, 4))
		0: it = random_load(7'($urandom));
		1: it.action = ACT_FIND;
		2: it.action = ACT_READ;
		3: it.action = ACT_NOP;
		default: ;
		endcase
		push_item(it);
	endtask

	// Phases under several search counts; one phase runs with no idling at all.
	task automatic test_random_sessions();
		logic [7:0] phase_counts [8];
		int         p;
		int         first;
		phase_counts = '{8'd128, 8'd255, 8'd1, 8'd0, 8'd127, 8'd129, 8'd64, 8'd0};
		phase_counts[7] = 8'($urandom);
		for (p = 0; p < 8; p++) begin
			write_entry_count(phase_counts[p]);
			idle_on = (p != 4);
			first = items_sent;
			while (items_sent - first < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) != 0)
					run_session();
				else
					send_noise();
				// Now and then the sender holds off until all answers are back.
				if ($urandom_range(0, 49) == 0)
					drain_replies();
			end
		end
		idle_on = 1'b1;
	endtask

	// The receiver stalls at random, except in the steady phase.
	always @(negedge clk) begin
		out_ready <= !idle_on || ($urandom_range(0, 99) >= 30);
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// Each result item is compared with the oldest awaited answer.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_replies.size() == 0) begin
				$error("result item with no answer awaited: %p", out_item);
				errors++;
			end else begin
				want = awaited_replies.pop_front();
				check_field("found", want.found, out_item.found);
				check_field("hit_type", want.hit_type, out_item.hit_type);
				check_field("hit_flags", want.hit_flags, out_item.hit_flags);
				check_field("hit_id", want.hit_id, out_item.hit_id);
				check_field("hit_next_id", want.hit_next_id, out_item.hit_next_id);
				check_field("hit_pos", want.hit_pos, out_item.hit_pos);
				check_field("hit_length", want.hit_length, out_item.hit_length);
				check_field("hit_crc", want.hit_crc, out_item.hit_crc);
				check_field("granted_size", want.granted_size, out_item.granted_size);
				check_field("read_address", want.read_address, out_item.read_address);
			end
		end
	end

	// The run ends if no item moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL directory_lookup_read_cursor_core");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_directed_lookups();
		test_fill_directory();
		test_random_sessions();
		drain_replies();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("PASS directory_lookup_read_cursor_core");
		else
			$display("FAIL directory_lookup_read_cursor_core");
		$finish;
	end

endmodule
